@@ rtl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 hash engine
// Holds round constants, initial hash values, the controller states and the
// round-unit control struct.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned BlockWords = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  // Round unit command from the controller
  typedef struct packed {
    logic       start;    // load working vars from chain value
    logic       run;      // advance one round
    logic [5:0] round;    // round number
  } rnd_ctrl_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    begin
      case (t)
        6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] j);
    logic [31:0] h;
    begin
      case (j)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

endpackage

@@ rtl/sha256_hash_engine.sv @@
// ----------------------------------------------------------------------------
// sha256_hash_engine: streaming SHA-256 top level
// Packs bytes into a block memory, compresses full blocks, pads and emits
// the eight digest words.
// ----------------------------------------------------------------------------
// Message bytes go into a 16-word block memory at one byte per cycle. The
// 64th byte of a block starts compression: 64 rounds at one per cycle and
// a fold into the chain value, during which no byte is taken. The schedule
// ring shares the block memory: each round reads the words it needs in the
// cycle before and writes the expanded word back. An end-of-message item
// pads the block one word per cycle (pad word, zero fill, length) and runs
// one or two further compressions, then the digest leaves as eight words,
// H0 first, the last marked by out_tlast. No item is taken until the digest
// is out.
module sha256_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_message
  input  logic        in_tuser,   // has_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD,
    PH_LEN
  } phase_t;

  // Control state
  sha_pkg::state_t state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [63:0]     bits_r, bits_nxt;
  logic [6:0]      rcnt_r, rcnt_nxt;   // 0..64 round counter + fold
  logic [2:0]      oidx_r, oidx_nxt;
  logic            eom_r, eom_nxt;
  logic [31:0]     h_r [8];
  logic [31:0]     cur_r;              // word being assembled
  logic [31:0]     cur_nxt;

  // Block / schedule memory: one write, four reads
  logic [31:0] mem_a [16];
  logic [31:0] mem_b [16];
  logic        we;
  logic [3:0]  wa;
  logic [31:0] wd;
  logic [3:0]  ra0, ra1, ra2, ra3;
  logic [31:0] rd0_r, rd1_r, rd2_r, rd3_r;
  logic [31:0] mem_c [16];
  logic [31:0] mem_d [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[wa] <= wd; mem_b[wa] <= wd; mem_c[wa] <= wd; mem_d[wa] <= wd;
    end
    rd0_r <= mem_a[ra0];
    rd1_r <= mem_b[ra1];
    rd2_r <= mem_c[ra2];
    rd3_r <= mem_d[ra3];
  end

  sha_pkg::rnd_ctrl_t rc;
  logic [31:0]        w_cur, w_new, ls0, ls1;
  logic [8*32-1:0]    chain, vars;
  logic [31:0]        w2v;

  always_comb begin
    for (int i = 0; i < 8; i++) chain[i*32 +: 32] = h_r[i];
  end

  sha_round u_round (
    .clk  (clk),
    .ctrl (rc),
    .w    (w_cur),
    .chain(chain),
    .vars (vars)
  );

  logic [5:0] t;
  logic [5:0] tn;
  assign t  = rcnt_r[5:0];
  assign tn = t + 6'd1;

  // Schedule expansion from registered reads of round t
  always_comb begin
    w2v  = rd0_r;
    ls1  = {w2v[16:0], w2v[31:17]} ^ {w2v[18:0], w2v[31:19]} ^ (w2v >> 10);
    ls0  = {rd1_r[6:0], rd1_r[31:7]} ^ {rd1_r[17:0], rd1_r[31:18]} ^ (rd1_r >> 3);
    w_new = ls1 + rd2_r + ls0 + rd3_r;
    w_cur = (t < 6'd16) ? rd3_r : w_new;
  end

  logic [5:0] pos;
  assign pos = bits_r[8:3];
  logic acc;
  assign acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    bits_nxt  = bits_r;
    rcnt_nxt  = rcnt_r;
    oidx_nxt  = oidx_r;
    eom_nxt   = eom_r;
    cur_nxt   = cur_r;
    in_tready = 1'b0;
    we = 1'b0; wa = '0; wd = '0;
    rc = '0;
    // read addresses for the next round (t+1 after prime)
    ra0 = 4'(tn - 6'd2); ra1 = 4'(tn - 6'd15); ra2 = 4'(tn - 6'd7); ra3 = tn[3:0];
    case (state_r)
      sha_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        ra0 = 4'd14; ra1 = 4'd1; ra2 = 4'd9; ra3 = 4'd0;
        if (acc) begin
          logic [5:0]  p;
          logic [31:0] c;
          logic        full;
          p = pos; c = cur_r; full = 1'b0;
          if (in_tuser) begin
            case (p[1:0])
              2'd0: c = {in_tdata, 24'd0};
              2'd1: c = {c[31:24], in_tdata, 16'd0};
              2'd2: c = {c[31:16], in_tdata, 8'd0};
              default: c = {c[31:8], in_tdata};
            endcase
            we = (p[1:0] == 2'd3); wa = p[5:2]; wd = c;
            bits_nxt = bits_r + 64'd8;
            full = (p == 6'd63);
            p = p + 6'd1;
          end
          cur_nxt = c;
          eom_nxt = in_tlast;
          if (full) begin
            state_nxt = sha_pkg::ST_ROUND; phase_nxt = PH_DATA;
          end else if (in_tlast) begin
            // place 0x80 in the held word, write it first when padding
            case (p[1:0])
              2'd0: c = 32'h80000000;
              2'd1: c = {c[31:24], 24'h800000};
              2'd2: c = {c[31:16], 16'h8000};
              default: c = {c[31:8], 8'h80};
            endcase
            cur_nxt = c;
            rcnt_nxt = {3'd1, p[5:2]};   // pad pointer, bit 4 marks the pad word
            state_nxt = sha_pkg::ST_FINAL;
            phase_nxt = (p >= 6'd56) ? PH_PAD : PH_LEN;
          end
          rc.start = full;
          if (full) rcnt_nxt = '0;
        end
      end
      sha_pkg::ST_FINAL: begin
        // write pad word, zero fill and length one word per cycle, then compress
        we = 1'b1;
        wa = rcnt_r[3:0];
        wd = rcnt_r[4] ? cur_r : '0;
        if (phase_r == PH_LEN && wa == 4'd14) wd = bits_r[63:32];
        if (phase_r == PH_LEN && wa == 4'd15) wd = bits_r[31:0];
        if (wa == 4'd15) begin
          ra0 = 4'd14; ra1 = 4'd1; ra2 = 4'd9; ra3 = 4'd0;
          rc.start = 1'b1;
          rcnt_nxt = '0;
          state_nxt = sha_pkg::ST_ROUND;
        end else begin
          rcnt_nxt = {3'd0, wa + 4'd1};
        end
      end
      sha_pkg::ST_ROUND: begin
        rc.round = t;
        if (rcnt_r[6]) begin
          // fold into chain, decide what follows
          if (phase_r == PH_DATA && !eom_r) begin
            state_nxt = sha_pkg::ST_IDLE;
          end else if (phase_r == PH_DATA) begin
            // block filled by last byte: pad block next
            cur_nxt = 32'h80000000;
            rcnt_nxt = 7'h10; phase_nxt = PH_LEN;
            state_nxt = sha_pkg::ST_FINAL;
          end else if (phase_r == PH_PAD) begin
            rcnt_nxt = '0; phase_nxt = PH_LEN;
            state_nxt = sha_pkg::ST_FINAL;
          end else begin
            oidx_nxt = '0;
            state_nxt = sha_pkg::ST_EMIT;
          end
        end else begin
          rc.run = 1'b1;
          rcnt_nxt = rcnt_r + 7'd1;
          if (t >= 6'd16) begin
            we = 1'b1; wa = t[3:0]; wd = w_new;
          end
        end
      end
      sha_pkg::ST_EMIT: begin
        if (out_tready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            state_nxt = sha_pkg::ST_IDLE;
            bits_nxt = '0;
            phase_nxt = PH_DATA;
          end
        end
      end
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = (state_r == sha_pkg::ST_EMIT);
  assign out_tdata  = h_r[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'd7);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_IDLE;
      phase_r <= PH_DATA;
      bits_r  <= '0;
      rcnt_r  <= '0;
      oidx_r  <= '0;
      eom_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      bits_r  <= bits_nxt;
      rcnt_r  <= rcnt_nxt;
      oidx_r  <= oidx_nxt;
      eom_r   <= eom_nxt;
    end
  end

  // Hold the word being assembled
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Chain value: reset to IV, fold after compression, reload after digest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::init_hash(3'(i));
    end else if (state_r == sha_pkg::ST_ROUND && rcnt_r[6]) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + vars[i*32 +: 32];
    end else if (state_r == sha_pkg::ST_EMIT && out_tready && oidx_r == 3'd7) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::init_hash(3'(i));
    end
  end

`ifndef SYNTH
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sha_pkg::ST_IDLE) |-> !in_tready) else $error("input taken while busy");
  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (out_tuser == $past(out_tuser) + 3'd1))
    else $error("digest word order broken");
  a_len_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (bits_r == 64'd0))
    else $error("length not cleared after digest");
`endif

endmodule

@@ rtl/sha_round.sv @@
// ----------------------------------------------------------------------------
// sha_round: SHA-256 compression round unit
// Holds working variables a..h and, while run is set, runs one round per cycle
// on the schedule word given; the controller adds vars into the chain value.
// ----------------------------------------------------------------------------
module sha_round (
  input  logic                  clk,
  input  sha_pkg::rnd_ctrl_t    ctrl,
  input  logic [31:0]           w,
  input  logic [8*32-1:0]       chain,
  output logic [8*32-1:0]       vars
);

  logic [31:0] v_r [8];
  logic [31:0] s1, ch, s0, mj, t1, t2;

  // Round logic
  always_comb begin
    s1 = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]}
       ^ {v_r[4][24:0], v_r[4][31:25]};
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + sha_pkg::round_k(ctrl.round) + w;
    s0 = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]}
       ^ {v_r[0][21:0], v_r[0][31:22]};
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = s0 + mj;
  end

  // Load or advance working variables
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain[i*32 +: 32];
    end else if (ctrl.run) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) vars[i*32 +: 32] = v_r[i];
  end

endmodule
